/* rtl/core/mseu_pkg.sv */
package mseu_pkg;

   localparam int NUM_REGS_DEF  = 32;
   localparam int MEM_WORDS_DEF = 8;

   localparam logic [5:0] OPC_RTYPE = 6'b000000;
   localparam logic [5:0] OPC_ANDI  = 6'b001100;
   localparam logic [5:0] OPC_ADDI  = 6'b001000;
   localparam logic [5:0] OPC_LW    = 6'b100011;
   localparam logic [5:0] OPC_SW    = 6'b101011;
   localparam logic [5:0] OPC_BEQ   = 6'b000100;

   localparam logic [5:0] FN_ADD = 6'b100000;
   localparam logic [5:0] FN_SUB = 6'b100010;
   localparam logic [5:0] FN_AND = 6'b100100;
   localparam logic [5:0] FN_OR  = 6'b100101;
   localparam logic [5:0] FN_SLT = 6'b101010;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_UNKNOWN  = 2'd1;
   localparam logic [1:0] ST_BAD_ADDR = 2'd2;

   typedef struct packed {
      logic [31:0] alu_result;
      logic [4:0]  dest_index;
      logic        reg_write;
      logic        load_write;
      logic        mem_write;
      logic        mem_read;
      logic [31:0] write_value;
      logic        branch_taken;
      logic        squashed;
      logic [1:0]  status;
      logic [15:0] skip_next;
   } exec_res_type;

   function automatic logic [31:0] reg_reset_value(input int idx);
      logic [31:0] val;
      case (idx)
         1: val = 32'd9;
         2: val = 32'd5;
         3: val = 32'd7;
         4: val = 32'd1;
         5: val = 32'd2;
         6: val = 32'd3;
         7: val = 32'd4;
         8: val = 32'd5;
         9: val = 32'd6;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

   function automatic logic [31:0] mem_reset_value(input int idx);
      logic [31:0] val;
      case (idx)
         0: val = 32'd5;
         1: val = 32'd9;
         2: val = 32'd4;
         3: val = 32'd8;
         4: val = 32'd7;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

/* rtl/core/mips_subset_instruction_executor_unit.sv */
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  req_instr_word
// rsp       out        rsp_valid / rsp_ready  rsp_alu_result .. rsp_status
//
// One transaction per cycle sustained while rsp is not stalled: acceptance reads the
// register file into the operand register, and exec_fire loads the result register,
// which drives rsp_valid. Writeback is registered with the result and is forwarded.
// After reset an init pass of max(NUM_REGS, MEM_WORDS) words loads the register file
// and data memory start values; req_ready is low meanwhile. A stalled rsp holds the
// result register and backs up into the operand register; req_ready then drops.
module mips_subset_instruction_executor_unit #(
   parameter int NUM_REGS  = mseu_pkg::NUM_REGS_DEF,
   parameter int MEM_WORDS = mseu_pkg::MEM_WORDS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_instr_word,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_alu_result,
   output logic [4:0]         rsp_dest_index,
   output logic               rsp_reg_write,
   output logic               rsp_mem_write,
   output logic signed [31:0] rsp_write_value,
   output logic               rsp_branch_taken,
   output logic               rsp_squashed,
   output logic [1:0]         rsp_status
);
   import mseu_pkg::*;

   localparam int INIT_LEN = (NUM_REGS > MEM_WORDS) ? NUM_REGS : MEM_WORDS;
   localparam int INIT_W   = (INIT_LEN > 1) ? $clog2(INIT_LEN) : 1;
   localparam int MEM_AW   = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

   logic              init_busy_ff;
   logic [INIT_W-1:0] init_cnt_ff;
   logic              init_reg_hit;
   logic              init_mem_hit;

   logic              s1_valid_ff;
   logic [31:0]       s1_instr_ff;
   logic              s2_valid_ff;
   logic [31:0]       s2_alu_ff;
   logic [4:0]        s2_dest_ff;
   logic              s2_reg_write_ff;
   logic              s2_mem_write_ff;
   logic [31:0]       s2_wval_ff;
   logic              s2_taken_ff;
   logic              s2_squashed_ff;
   logic [1:0]        s2_status_ff;
   logic              s2_load_ff;

   logic              wb_en_ff;
   logic [4:0]        wb_idx_ff;
   logic [31:0]       wb_alu_ff;
   logic              wb_load_ff;
   logic [31:0]       wb_data;

   logic [15:0]       skip_ff;

   logic              s2_free;
   logic              exec_fire;
   logic              accept;

   logic [31:0]       rf_a;
   logic [31:0]       rf_b;
   logic [31:0]       op_a;
   logic [31:0]       op_b;
   logic              rf_wr_en;
   logic [4:0]        rf_wr_idx;
   logic [31:0]       rf_wr_data;

   logic              mem_en;
   logic              mem_we;
   logic [MEM_AW-1:0] mem_addr;
   logic [31:0]       mem_wdata;
   logic [31:0]       mem_rdata;

   exec_res_type      exec_res;

   assign s2_free   = !s2_valid_ff || rsp_ready;
   assign exec_fire = s1_valid_ff && s2_free;
   assign req_ready = !init_busy_ff && (!s1_valid_ff || exec_fire);
   assign accept    = req_valid && req_ready;

   assign init_reg_hit = int'(init_cnt_ff) < NUM_REGS;
   assign init_mem_hit = int'(init_cnt_ff) < MEM_WORDS;

   assign wb_data = wb_load_ff ? mem_rdata : wb_alu_ff;
   assign op_a = (wb_en_ff && (wb_idx_ff == s1_instr_ff[25:21])) ? wb_data : rf_a;
   assign op_b = (wb_en_ff && (wb_idx_ff == s1_instr_ff[20:16])) ? wb_data : rf_b;

   assign rf_wr_en   = init_busy_ff ? init_reg_hit : wb_en_ff;
   assign rf_wr_idx  = init_busy_ff ? 5'(init_cnt_ff) : wb_idx_ff;
   assign rf_wr_data = init_busy_ff ? reg_reset_value(int'(init_cnt_ff)) : wb_data;

   assign mem_en    = init_busy_ff ? init_mem_hit :
                      (exec_fire && (exec_res.mem_write || exec_res.mem_read));
   assign mem_we    = init_busy_ff || exec_res.mem_write;
   assign mem_addr  = init_busy_ff ? MEM_AW'(init_cnt_ff) :
                      exec_res.alu_result[MEM_AW+1:2];
   assign mem_wdata = init_busy_ff ? mem_reset_value(int'(init_cnt_ff)) : op_b;

   mseu_regfile #(
      .NUM_REGS (NUM_REGS)
   ) u_regfile (
      .clock     (clock),
      .rd_en     (accept),
      .rd_idx_a  (req_instr_word[25:21]),
      .rd_idx_b  (req_instr_word[20:16]),
      .wr_en     (rf_wr_en),
      .wr_idx    (rf_wr_idx),
      .wr_data   (rf_wr_data),
      .rd_data_a (rf_a),
      .rd_data_b (rf_b)
   );

   mseu_dmem #(
      .MEM_WORDS (MEM_WORDS),
      .MEM_AW    (MEM_AW)
   ) u_dmem (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   mseu_exec #(
      .NUM_REGS  (NUM_REGS),
      .MEM_WORDS (MEM_WORDS)
   ) u_exec (
      .instr      (s1_instr_ff),
      .op_a       (op_a),
      .op_b       (op_b),
      .skip_count (skip_ff),
      .res        (exec_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         init_busy_ff <= 1'b1;
         init_cnt_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         wb_en_ff     <= 1'b0;
         skip_ff      <= 16'd0;
      end else begin
         if (init_busy_ff) begin
            if (init_cnt_ff == INIT_W'(INIT_LEN - 1)) begin
               init_busy_ff <= 1'b0;
            end else begin
               init_cnt_ff <= init_cnt_ff + 1'b1;
            end
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (exec_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (exec_fire) begin
            s2_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            s2_valid_ff <= 1'b0;
         end
         wb_en_ff <= exec_fire && exec_res.reg_write;
         if (exec_fire) begin
            skip_ff <= exec_res.skip_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_instr_ff <= req_instr_word;
      end
      if (exec_fire) begin
         s2_alu_ff       <= exec_res.alu_result;
         s2_dest_ff      <= exec_res.dest_index;
         s2_reg_write_ff <= exec_res.reg_write;
         s2_mem_write_ff <= exec_res.mem_write;
         s2_wval_ff      <= exec_res.write_value;
         s2_taken_ff     <= exec_res.branch_taken;
         s2_squashed_ff  <= exec_res.squashed;
         s2_status_ff    <= exec_res.status;
         s2_load_ff      <= exec_res.load_write;
         wb_idx_ff       <= exec_res.dest_index;
         wb_alu_ff       <= exec_res.write_value;
         wb_load_ff      <= exec_res.load_write;
      end
   end

   assign rsp_valid        = s2_valid_ff;
   assign rsp_alu_result   = s2_alu_ff;
   assign rsp_dest_index   = s2_dest_ff;
   assign rsp_reg_write    = s2_reg_write_ff;
   assign rsp_mem_write    = s2_mem_write_ff;
   assign rsp_write_value  = s2_load_ff ? mem_rdata : s2_wval_ff;
   assign rsp_branch_taken = s2_taken_ff;
   assign rsp_squashed     = s2_squashed_ff;
   assign rsp_status       = s2_status_ff;

`ifndef NO_ASSERTIONS
   a_wb_target_legal: assert property (@(posedge clock) disable iff (reset)
      wb_en_ff |-> (wb_idx_ff != 5'd0) && ({1'b0, wb_idx_ff} < 6'(NUM_REGS)))
      else $error("writeback to register zero or beyond the file");

   a_squash_no_effect: assert property (@(posedge clock) disable iff (reset)
      exec_fire && exec_res.squashed |->
         !exec_res.reg_write && !exec_res.mem_write && !exec_res.branch_taken)
      else $error("squashed transaction changed state");

   a_branch_arms_skip: assert property (@(posedge clock) disable iff (reset)
      exec_fire && exec_res.branch_taken && (s1_instr_ff[15:0] != 16'd0) |=>
         skip_ff != 16'd0)
      else $error("taken branch did not arm the skip counter");

   a_store_exclusive: assert property (@(posedge clock) disable iff (reset)
      exec_fire && exec_res.mem_write |->
         !exec_res.reg_write && (exec_res.status == ST_OK))
      else $error("store with register write or error status");
`endif

endmodule

/* rtl/core/mseu_regfile.sv */
module mseu_regfile #(
   parameter int NUM_REGS = mseu_pkg::NUM_REGS_DEF
) (
   input  logic        clock,
   input  logic        rd_en,
   input  logic [4:0]  rd_idx_a,
   input  logic [4:0]  rd_idx_b,
   input  logic        wr_en,
   input  logic [4:0]  wr_idx,
   input  logic [31:0] wr_data,
   output logic [31:0] rd_data_a,
   output logic [31:0] rd_data_b
);
   import mseu_pkg::*;

   localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

   logic [31:0] regs_mem [NUM_REGS];
   logic [4:0]  idx_a_ff;
   logic [4:0]  idx_b_ff;
   logic [31:0] data_a_ff;
   logic [31:0] data_b_ff;
   logic        a_in_range;
   logic        b_in_range;
   logic        a_wr_hit;
   logic        b_wr_hit;

   assign a_in_range = {1'b0, rd_idx_a} < 6'(NUM_REGS);
   assign b_in_range = {1'b0, rd_idx_b} < 6'(NUM_REGS);
   assign a_wr_hit   = wr_en && (wr_idx == rd_idx_a);
   assign b_wr_hit   = wr_en && (wr_idx == rd_idx_b);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         regs_mem[wr_idx[AW-1:0]] <= wr_data;
      end
   end

   // read ports track later writes to the held index
   always_ff @(posedge clock) begin
      if (rd_en) begin
         idx_a_ff  <= rd_idx_a;
         idx_b_ff  <= rd_idx_b;
         data_a_ff <= !a_in_range ? 32'd0 :
                      a_wr_hit    ? wr_data : regs_mem[rd_idx_a[AW-1:0]];
         data_b_ff <= !b_in_range ? 32'd0 :
                      b_wr_hit    ? wr_data : regs_mem[rd_idx_b[AW-1:0]];
      end else begin
         if (wr_en && (wr_idx == idx_a_ff)) begin
            data_a_ff <= wr_data;
         end
         if (wr_en && (wr_idx == idx_b_ff)) begin
            data_b_ff <= wr_data;
         end
      end
   end

   assign rd_data_a = data_a_ff;
   assign rd_data_b = data_b_ff;

endmodule

/* rtl/core/mseu_dmem.sv */
module mseu_dmem #(
   parameter int MEM_WORDS = mseu_pkg::MEM_WORDS_DEF,
   parameter int MEM_AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1
) (
   input  logic              clock,
   input  logic              en,
   input  logic              we,
   input  logic [MEM_AW-1:0] addr,
   input  logic [31:0]       wdata,
   output logic [31:0]       rdata
);
   import mseu_pkg::*;

   logic [31:0] words_mem [MEM_WORDS];
   logic [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            words_mem[addr] <= wdata;
         end else begin
            rdata_ff <= words_mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/mseu_exec.sv */
module mseu_exec #(
   parameter int NUM_REGS  = mseu_pkg::NUM_REGS_DEF,
   parameter int MEM_WORDS = mseu_pkg::MEM_WORDS_DEF
) (
   input  logic [31:0]           instr,
   input  logic [31:0]           op_a,
   input  logic [31:0]           op_b,
   input  logic [15:0]           skip_count,
   output mseu_pkg::exec_res_type res
);
   import mseu_pkg::*;

   logic [5:0]  op;
   logic [4:0]  rt;
   logic [4:0]  rd;
   logic [5:0]  fn;
   logic [15:0] imm;
   logic [31:0] imm_ext;
   logic [31:0] addr;
   logic        addr_ok;
   logic        rt_ok;
   logic        rd_ok;
   logic [31:0] r_val;
   logic        r_known;

   assign op      = instr[31:26];
   assign rt      = instr[20:16];
   assign rd      = instr[15:11];
   assign fn      = instr[5:0];
   assign imm     = instr[15:0];
   assign imm_ext = {16'h0000, imm};
   assign addr    = op_a + imm_ext;
   assign addr_ok = (addr[1:0] == 2'b00) && (addr[31:2] < 30'(MEM_WORDS));
   assign rt_ok   = (rt != 5'd0) && ({1'b0, rt} < 6'(NUM_REGS));
   assign rd_ok   = (rd != 5'd0) && ({1'b0, rd} < 6'(NUM_REGS));

   always_comb begin
      r_known = 1'b1;
      case (fn)
         FN_ADD:  r_val = op_a + op_b;
         FN_SUB:  r_val = op_a - op_b;
         FN_AND:  r_val = op_a & op_b;
         FN_OR:   r_val = op_a | op_b;
         FN_SLT:  r_val = {31'd0, $signed(op_a) < $signed(op_b)};
         default: begin
            r_val   = 32'd0;
            r_known = 1'b0;
         end
      endcase
   end

   always_comb begin
      res = '0;
      if (skip_count != 16'd0) begin
         res.squashed  = 1'b1;
         res.skip_next = skip_count - 16'd1;
      end else begin
         case (op)
            OPC_RTYPE: begin
               if (r_known) begin
                  res.alu_result = r_val;
                  res.dest_index = rd;
                  if (rd_ok) begin
                     res.reg_write   = 1'b1;
                     res.write_value = r_val;
                  end
               end else begin
                  res.status = ST_UNKNOWN;
               end
            end
            OPC_ANDI: begin
               res.alu_result = op_a & imm_ext;
               res.dest_index = rt;
               if (rt_ok) begin
                  res.reg_write   = 1'b1;
                  res.write_value = op_a & imm_ext;
               end
            end
            OPC_ADDI: begin
               res.alu_result = addr;
               res.dest_index = rt;
               if (rt_ok) begin
                  res.reg_write   = 1'b1;
                  res.write_value = addr;
               end
            end
            OPC_LW: begin
               res.alu_result = addr;
               if (!addr_ok) begin
                  res.status = ST_BAD_ADDR;
               end else begin
                  res.dest_index = rt;
                  res.mem_read   = 1'b1;
                  if (rt_ok) begin
                     res.reg_write  = 1'b1;
                     res.load_write = 1'b1;
                  end
               end
            end
            OPC_SW: begin
               res.alu_result = addr;
               if (!addr_ok) begin
                  res.status = ST_BAD_ADDR;
               end else begin
                  res.mem_write   = 1'b1;
                  res.write_value = op_b;
               end
            end
            OPC_BEQ: begin
               res.alu_result = op_a - op_b;
               if (op_a == op_b) begin
                  res.branch_taken = 1'b1;
                  res.skip_next    = imm;
               end
            end
            default: begin
               res.status = ST_UNKNOWN;
            end
         endcase
      end
   end

endmodule

/* tb/tb.sv */
module tb;
   import mseu_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int WANT_DEPTH = 256;
   localparam int DMEM_AW = (MEM_WORDS_DEF > 1) ? $clog2(MEM_WORDS_DEF) : 1;
   localparam logic [31:0] GPR_START [0:9] = '{0, 9, 5, 7, 1, 2, 3, 4, 5, 6};
   localparam logic [31:0] DMEM_START [0:4] = '{5, 9, 4, 8, 7};

   typedef struct packed {
      logic [31:0] alu_result;
      logic [4:0]  dest_index;
      logic        reg_write;
      logic        mem_write;
      logic [31:0] write_value;
      logic        branch_taken;
      logic        squashed;
      logic [1:0]  status;
   } exec_outcome_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [31:0]        req_instr_word = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_alu_result;
   logic [4:0]         rsp_dest_index;
   logic               rsp_reg_write;
   logic               rsp_mem_write;
   logic signed [31:0] rsp_write_value;
   logic               rsp_branch_taken;
   logic               rsp_squashed;
   logic [1:0]         rsp_status;

   logic [31:0] gpr [0:NUM_REGS_DEF-1];
   logic [31:0] dmem [0:MEM_WORDS_DEF-1];
   logic [15:0] skip_left;
   exec_outcome_type want_fifo [0:WANT_DEPTH-1];

   int sent_count = 0;
   int checked_count = 0;
   int fail_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   int rsp_hold_left = 0;

   mips_subset_instruction_executor_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_instr_word   (req_instr_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_alu_result   (rsp_alu_result),
      .rsp_dest_index   (rsp_dest_index),
      .rsp_reg_write    (rsp_reg_write),
      .rsp_mem_write    (rsp_mem_write),
      .rsp_write_value  (rsp_write_value),
      .rsp_branch_taken (rsp_branch_taken),
      .rsp_squashed     (rsp_squashed),
      .rsp_status       (rsp_status)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // register writes to r0 are dropped but still report the index
   function automatic void write_gpr(input logic [4:0] idx, input logic [31:0] val,
                                     inout exec_outcome_type r);
      r.dest_index = idx;
      if (idx != 5'd0) begin
         gpr[idx] = val;
         r.reg_write = 1'b1;
         r.write_value = val;
      end
   endfunction

   function automatic exec_outcome_type execute_instr(input logic [31:0] w);
      exec_outcome_type r;
      logic [5:0]  op;
      logic [5:0]  fn;
      logic [4:0]  rs;
      logic [4:0]  rt;
      logic [4:0]  rd;
      logic [15:0] imm;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] val;
      logic        known;
      r = '0;
      op = w[31:26];
      rs = w[25:21];
      rt = w[20:16];
      rd = w[15:11];
      fn = w[5:0];
      imm = w[15:0];
      if (skip_left != 16'd0) begin
         skip_left = skip_left - 16'd1;
         r.squashed = 1'b1;
         return r;
      end
      a = gpr[rs];
      b = gpr[rt];
      case (op)
         OPC_RTYPE: begin
            known = 1'b1;
            case (fn)
               FN_ADD: val = a + b;
               FN_SUB: val = a - b;
               FN_AND: val = a & b;
               FN_OR:  val = a | b;
               FN_SLT: val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
               default: begin
                  val = '0;
                  known = 1'b0;
               end
            endcase
            if (known) begin
               r.alu_result = val;
               write_gpr(rd, val, r);
            end else begin
               r.status = ST_UNKNOWN;
            end
         end
         OPC_ANDI: begin
            r.alu_result = a & {16'd0, imm};
            write_gpr(rt, r.alu_result, r);
         end
         OPC_ADDI: begin
            r.alu_result = a + {16'd0, imm};
            write_gpr(rt, r.alu_result, r);
         end
         OPC_LW, OPC_SW: begin
            val = a + {16'd0, imm};
            r.alu_result = val;
            if (val[1:0] != 2'b00 || (val >> 2) >= MEM_WORDS_DEF) begin
               r.status = ST_BAD_ADDR;
            end else if (op == OPC_LW) begin
               write_gpr(rt, dmem[val[DMEM_AW+1:2]], r);
            end else begin
               dmem[val[DMEM_AW+1:2]] = b;
               r.mem_write = 1'b1;
               r.write_value = b;
            end
         end
         OPC_BEQ: begin
            r.alu_result = a - b;
            if (a == b) begin
               r.branch_taken = 1'b1;
               skip_left = imm;
            end
         end
         default: r.status = ST_UNKNOWN;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] r_word(input logic [5:0] fn, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [4:0] rd,
                                          input logic [4:0] shamt = 5'd0);
      return {OPC_RTYPE, rs, rt, rd, shamt, fn};
   endfunction

   function automatic logic [31:0] i_word(input logic [5:0] op, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic logic [31:0] random_instr();
      logic [31:0] w;
      logic [5:0]  fn;
      logic [5:0]  op;
      logic [4:0]  rt;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      w = $urandom;
      if (pick < 30) begin
         case ($urandom_range(0, 4))
            0: fn = FN_ADD;
            1: fn = FN_SUB;
            2: fn = FN_AND;
            3: fn = FN_OR;
            default: fn = FN_SLT;
         endcase
         w = {OPC_RTYPE, w[25:6], fn};
      end else if (pick < 42) begin
         w = {($urandom_range(0, 1) != 0) ? OPC_ANDI : OPC_ADDI, w[25:0]};
      end else if (pick < 70) begin
         op = ($urandom_range(0, 1) != 0) ? OPC_LW : OPC_SW;
         if ($urandom_range(0, 3) != 0)
            w = {op, 5'd0, w[20:16], 11'd0, 3'($urandom_range(0, 7)), 2'b00};
         else
            w = {op, w[25:0]};
      end else if (pick < 82) begin
         rt = ($urandom_range(0, 1) != 0) ? w[25:21] : w[20:16];
         w = {OPC_BEQ, w[25:21], rt, 16'($urandom_range(0, 5))};
      end else if (pick < 87) begin
         w = {OPC_RTYPE, w[25:0]};
      end else if (w[31:26] == OPC_BEQ) begin
         // keep noise from loading huge skip counts
         w[27] = 1'b1;
      end
      return w;
   endfunction

   task automatic send_instr(input logic [31:0] w);
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_instr_word <= w;
      do @(posedge clock); while (!req_ready);
      want_fifo[sent_count % WANT_DEPTH] = execute_instr(w);
      sent_count++;
   endtask

   task automatic test_alu_ops();
      send_instr(r_word(FN_ADD, 5'd1, 5'd2, 5'd10));
      send_instr(r_word(FN_SUB, 5'd2, 5'd1, 5'd11));
      send_instr(r_word(FN_AND, 5'd1, 5'd3, 5'd12));
      send_instr(r_word(FN_OR, 5'd1, 5'd3, 5'd13, 5'h1F));
      send_instr(r_word(FN_SLT, 5'd11, 5'd1, 5'd14));
      send_instr(r_word(FN_SLT, 5'd1, 5'd11, 5'd15));
      send_instr(r_word(FN_ADD, 5'd1, 5'd2, 5'd0));
      send_instr(r_word(6'h3F, 5'd1, 5'd2, 5'd3));
      send_instr(32'hFFFF_FFFF);
      send_instr(32'h0000_0000);
   endtask

   task automatic test_imm_ops();
      send_instr(i_word(OPC_ANDI, 5'd11, 5'd16, 16'hFFFF));
      send_instr(i_word(OPC_ADDI, 5'd11, 5'd17, 16'hFFFF));
      send_instr(i_word(OPC_ADDI, 5'd1, 5'd0, 16'd1));
      send_instr(i_word(OPC_ANDI, 5'd31, 5'd31, 16'd0));
   endtask

   task automatic test_memory();
      send_instr(i_word(OPC_LW, 5'd0, 5'd18, 16'd4));
      send_instr(i_word(OPC_LW, 5'd11, 5'd19, 16'd0));
      send_instr(i_word(OPC_LW, 5'd11, 5'd19, 16'd4));
      send_instr(i_word(OPC_SW, 5'd0, 5'd1, 16'd28));
      send_instr(i_word(OPC_LW, 5'd0, 5'd20, 16'd28));
      send_instr(i_word(OPC_SW, 5'd0, 5'd1, 16'd2));
      send_instr(i_word(OPC_SW, 5'd0, 5'd1, 16'd32));
      send_instr(i_word(OPC_LW, 5'd0, 5'd21, 16'hFFFF));
   endtask

   task automatic test_branches();
      send_instr(i_word(OPC_BEQ, 5'd1, 5'd2, 16'hFFFF));
      send_instr(i_word(OPC_BEQ, 5'd0, 5'd0, 16'd0));
      send_instr(r_word(FN_ADD, 5'd1, 5'd1, 5'd22));
      send_instr(i_word(OPC_BEQ, 5'd2, 5'd8, 16'd2));
      send_instr(i_word(OPC_BEQ, 5'd0, 5'd0, 16'd7));
      send_instr(r_word(FN_ADD, 5'd1, 5'd2, 5'd23));
      send_instr(r_word(FN_SUB, 5'd1, 5'd2, 5'd24));
   endtask

   task automatic test_long_skip();
      send_instr(i_word(OPC_BEQ, 5'd0, 5'd0, 16'h0101));
      repeat (16'h0101) send_instr($urandom);
      send_instr(r_word(FN_OR, 5'd1, 5'd2, 5'd25));
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_idle_pct <= 0;
      rsp_hold_left <= 120;
      repeat (40) send_instr(random_instr());
   endtask

   task automatic test_random(input int count);
      repeat (count) send_instr(random_instr());
   endtask

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      exec_outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (checked_count == sent_count) begin
            $error("unexpected transaction: alu_result %0h", rsp_alu_result);
            fail_count++;
         end else begin
            want = want_fifo[checked_count % WANT_DEPTH];
            checked_count++;
            check_field("alu_result", want.alu_result, rsp_alu_result);
            check_field("dest_index", 32'(want.dest_index), 32'(rsp_dest_index));
            check_field("reg_write", 32'(want.reg_write), 32'(rsp_reg_write));
            check_field("mem_write", 32'(want.mem_write), 32'(rsp_mem_write));
            check_field("write_value", want.write_value, rsp_write_value);
            check_field("branch_taken", 32'(want.branch_taken), 32'(rsp_branch_taken));
            check_field("squashed", 32'(want.squashed), 32'(rsp_squashed));
            check_field("status", 32'(want.status), 32'(rsp_status));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < NUM_REGS_DEF; i++) gpr[i] = (i < 10) ? GPR_START[i] : '0;
      for (int i = 0; i < MEM_WORDS_DEF; i++) dmem[i] = (i < 5) ? DMEM_START[i] : '0;
      skip_left = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 16;
      rsp_idle_pct <= 69;
      test_alu_ops();
      test_imm_ops();
      test_memory();
      test_branches();
      test_long_skip();
      test_random(190);

      send_idle_pct = 69;
      rsp_idle_pct <= 16;
      test_random(190);

      test_backpressure();

      send_idle_pct = 0;
      rsp_idle_pct <= 0;
      test_random(190);

      req_valid <= 1'b0;
      while (checked_count != sent_count) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
